@@ sv/ffsa_pkg.sv @@
// Shared types and constants for the first-fit segment allocator.
// No dependencies; imported by every module of the block.
package ffsa_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int OFFSET_BITS  = 20;
  localparam int ADDR_W       = 32;
  localparam int SIZE_W       = 21;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W        = OFFSET_BITS + 3;

  localparam logic [SIZE_W-1:0] SEG_SIZE_RST = SIZE_W'(4096);

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_SIZE  = 1'b1;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } ffsa_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_TAIL,
    S_INS,
    S_PUT,
    S_DEL,
    S_DONE
  } ffsa_state_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] bytes;
  } ffsa_entry_t;

  typedef struct packed {
    logic         load;
    logic         rd;
    logic         ptr_dec;
    logic         ptr_cnt_m1;
    logic         scan_upd;
    logic         mark_ins;
    logic         mark_tail;
    logic         mv_up;
    logic         mv_dn;
    logic         put;
    logic         cnt_dec;
    logic         stage;
    ffsa_status_t stage_status;
    logic         emit;
  } ffsa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic full;
    logic single;
    logic last;
    logic inner_fit;
    logic tail_fit;
    logic match;
    logic ins_more;
    logic del_more;
    logic rvld;
  } ffsa_stat_t;

endpackage

@@ sv/ffsa_ctrl.sv @@
// Sequencer of the allocator: scan, shift, insert, remove and result hand-off.
// Depends on ffsa_pkg; drives the datapath ffsa_dp through ffsa_cmd_t.
module ffsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ffsa_pkg::ffsa_stat_t st,
  output ffsa_pkg::ffsa_cmd_t  cmd
);
  import ffsa_pkg::*;

  ffsa_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cmd              = '0;
    cmd.stage_status = ST_OK;
    in_ready         = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (!st.is_free) begin
          if (st.too_large) begin
            cmd.stage        = 1'b1;
            cmd.stage_status = ST_NOFIT;
            state_nxt        = S_DONE;
          end else if (st.full) begin
            cmd.stage        = 1'b1;
            cmd.stage_status = ST_FULL;
            state_nxt        = S_DONE;
          end else begin
            cmd.rd    = 1'b1;
            state_nxt = S_SCAN;
          end
        end else if (st.single) begin
          cmd.stage        = 1'b1;
          cmd.stage_status = ST_UNKNOWN;
          state_nxt        = S_DONE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!st.is_free) begin
          if (st.inner_fit) begin
            cmd.mark_ins   = 1'b1;
            cmd.ptr_cnt_m1 = 1'b1;
            state_nxt      = S_INS;
          end else begin
            cmd.scan_upd = 1'b1;
            if (st.last) begin
              state_nxt = S_TAIL;
            end else begin
              cmd.rd = 1'b1;
            end
          end
        end else if (st.match) begin
          state_nxt = S_DEL;
        end else if (st.last) begin
          cmd.stage        = 1'b1;
          cmd.stage_status = ST_UNKNOWN;
          state_nxt        = S_DONE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_TAIL: begin
        if (st.tail_fit) begin
          cmd.mark_tail = 1'b1;
          state_nxt     = S_PUT;
        end else begin
          cmd.stage        = 1'b1;
          cmd.stage_status = ST_NOFIT;
          state_nxt        = S_DONE;
        end
      end
      S_INS: begin
        cmd.rd      = st.ins_more;
        cmd.ptr_dec = 1'b1;
        cmd.mv_up   = 1'b1;
        if (!st.ins_more && !st.rvld) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DEL: begin
        cmd.rd    = st.del_more;
        cmd.mv_dn = 1'b1;
        if (!st.del_more && !st.rvld) begin
          cmd.cnt_dec      = 1'b1;
          cmd.stage        = 1'b1;
          cmd.stage_status = ST_OK;
          state_nxt        = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/ffsa_dp.sv @@
// Datapath of the allocator: block table memory, count, scan pointer, compare logic,
// configuration registers and result registers. Depends on ffsa_pkg.
module ffsa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffsa_pkg::ffsa_cmd_t           cmd,
  output ffsa_pkg::ffsa_stat_t          st,
  input  logic                          in_cmd,
  input  logic [19:0]                   in_alloc_size,
  input  logic [ffsa_pkg::ADDR_W-1:0]   in_object_address,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [ffsa_pkg::ADDR_W-1:0]   cfg_wdata,
  output logic [1:0]                    out_status,
  output logic [ffsa_pkg::ADDR_W-1:0]   out_granted_address
);
  import ffsa_pkg::*;

  ffsa_entry_t            tbl_r [MAX_BLOCKS];
  ffsa_entry_t            rdata_r;
  ffsa_entry_t            ent;
  ffsa_entry_t            wdata;
  logic                   rhead_r;
  logic                   rvld_r;
  logic [IDX_W-1:0]       raddr_r;
  logic [IDX_W-1:0]       pos_r;
  logic [IDX_W-1:0]       waddr;
  logic                   mem_we;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       ptr_r;
  logic                   cmd_r;
  logic [19:0]            size_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [ADDR_W-1:0]      seg_base_r;
  logic [SIZE_W-1:0]      seg_size_r;
  logic [SUM_W-1:0]       prev_end_r;
  logic [OFFSET_BITS-1:0] new_start_r;
  ffsa_status_t           stat_r;
  logic [ADDR_W-1:0]      grant_r;
  ffsa_status_t           out_status_r;
  logic [ADDR_W-1:0]      out_grant_r;
  logic [SUM_W-1:0]       need;
  logic [SUM_W-1:0]       ent_end;
  logic [SUM_W-1:0]       lim_prev;
  logic [ADDR_W-1:0]      ent_addr;
  logic [ADDR_W-1:0]      grant_calc;

  assign ent        = rhead_r ? '0 : rdata_r;
  assign need       = SUM_W'(size_r) + SUM_W'(HEADER_BYTES);
  assign ent_end    = SUM_W'(ent.start) + SUM_W'(ent.bytes) + SUM_W'(HEADER_BYTES);
  assign lim_prev   = prev_end_r + need;
  assign ent_addr   = seg_base_r + ADDR_W'(ent.start) + ADDR_W'(HEADER_BYTES);
  assign grant_calc = seg_base_r + ADDR_W'(new_start_r) + ADDR_W'(HEADER_BYTES);

  always_comb begin
    st.is_free   = (cmd_r == CMD_FREE);
    st.too_large = ({1'b0, size_r} >= seg_size_r);
    st.full      = (cnt_r == CNT_W'(MAX_BLOCKS));
    st.single    = (cnt_r == CNT_W'(1));
    st.last      = ({1'b0, raddr_r} == (cnt_r - CNT_W'(1)));
    st.inner_fit = (raddr_r != '0) && (SUM_W'(ent.start) >= lim_prev);
    st.tail_fit  = (SUM_W'(seg_size_r) >= lim_prev);
    st.match     = (ent_addr == addr_r);
    st.ins_more  = (ptr_r >= {1'b0, pos_r});
    st.del_more  = (ptr_r < cnt_r);
    st.rvld      = rvld_r;
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = pos_r;
    wdata  = rdata_r;
    if (cmd.put) begin
      mem_we      = 1'b1;
      wdata.start = new_start_r;
      wdata.bytes = size_r;
    end else if (cmd.mv_up && rvld_r) begin
      mem_we = 1'b1;
      waddr  = raddr_r + IDX_W'(1);
    end else if (cmd.mv_dn && rvld_r) begin
      mem_we = 1'b1;
      waddr  = raddr_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_r[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= tbl_r[ptr_r[IDX_W-1:0]];
      raddr_r <= ptr_r[IDX_W-1:0];
      rhead_r <= (ptr_r[IDX_W-1:0] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
      ptr_r  <= '0;
      cnt_r  <= CNT_W'(1);
    end else begin
      rvld_r <= cmd.rd;
      if (cmd.load) begin
        ptr_r <= (in_cmd == CMD_FREE) ? CNT_W'(1) : '0;
      end else if (cmd.ptr_cnt_m1) begin
        ptr_r <= cnt_r - CNT_W'(1);
      end else if (cmd.rd) begin
        ptr_r <= cmd.ptr_dec ? ptr_r - CNT_W'(1) : ptr_r + CNT_W'(1);
      end
      if (cmd.put) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_base_r <= '0;
      seg_size_r <= SEG_SIZE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE) begin
        seg_base_r <= cfg_wdata;
      end
      if (cfg_index == CFG_SIZE) begin
        seg_size_r <= cfg_wdata[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      size_r <= in_alloc_size;
      addr_r <= in_object_address;
    end
    if (cmd.scan_upd) begin
      prev_end_r <= ent_end;
    end
    if (cmd.mark_ins) begin
      pos_r       <= raddr_r;
      new_start_r <= prev_end_r[OFFSET_BITS-1:0];
    end else if (cmd.mark_tail) begin
      pos_r       <= cnt_r[IDX_W-1:0];
      new_start_r <= prev_end_r[OFFSET_BITS-1:0];
    end
    if (cmd.put) begin
      stat_r  <= ST_OK;
      grant_r <= grant_calc;
    end else if (cmd.stage) begin
      stat_r  <= cmd.stage_status;
      grant_r <= '0;
    end
    if (cmd.emit) begin
      out_status_r <= stat_r;
      out_grant_r  <= grant_r;
    end
  end

  assign out_status          = out_status_r;
  assign out_granted_address = out_grant_r;

endmodule

@@ sv/first_fit_segment_allocator_top.sv @@
// Input accept to out_valid: a request rejected up front goes straight to the result, else
// the time grows with the entries scanned plus the entries shifted; a stalled out_ holds it longer.
// Scan and shift set the rate.
// One request in work at a time; the next is taken while a result waits at out_.
// Reset (rst_n low, synchronous): head block only, segment_base 0, segment_size 4096.
module first_fit_segment_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [19:0]                 in_alloc_size,
  input  logic [ffsa_pkg::ADDR_W-1:0] in_object_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [ffsa_pkg::ADDR_W-1:0] out_granted_address,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [ffsa_pkg::ADDR_W-1:0] cfg_wdata
);
  import ffsa_pkg::*;

  ffsa_cmd_t  cmd;
  ffsa_stat_t st;

  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ffsa_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_cmd              (in_cmd),
    .in_alloc_size       (in_alloc_size),
    .in_object_address   (in_object_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_status          (out_status),
    .out_granted_address (out_granted_address)
  );

endmodule

@@ sv/ffsa_checker.sv @@
// Port-level checks for the allocator top level, with the bind that attaches them.
// Depends on ffsa_pkg and first_fit_segment_allocator_top.
module ffsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [ffsa_pkg::ADDR_W-1:0] out_granted_address
);
  import ffsa_pkg::*;

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_granted_address))
    else $error("word changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_granted_address == '0)
    else $error("failed word carries an address");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("word delivered without a request");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests in flight");

endmodule

bind first_fit_segment_allocator_top ffsa_checker u_ffsa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_granted_address (out_granted_address)
);
